>>> src/cnpj_pkg.sv
// ----------------------------------------------------------------------------
// cnpj_pkg
// Shared widths, constants and the queue item type of the CNPJ check-digit core.
// ----------------------------------------------------------------------------
package cnpj_pkg;

    localparam int BaseW        = 40;
    localparam int FullW        = 47;
    localparam int DigitW       = 4;
    localparam int NumDigits    = 12;
    localparam int BcdW         = NumDigits * DigitW;
    localparam int BitsPerStage = 5;
    localparam int DdStages     = BaseW / BitsPerStage;
    localparam int SumW         = 10;
    localparam int InDataW      = 40;
    localparam int OutDataW     = 56;

    localparam logic [BaseW-1:0] BaseLimit = 40'd999999999999;

    typedef logic [DigitW-1:0] weight_arr_t [NumDigits+1];
    localparam weight_arr_t Weights = '{4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8,
                                        4'd9, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6};

    // one classified item as it travels from the front to the back
    typedef struct packed {
        logic [BaseW-1:0] base;
        logic             invalid;
    } item_t;

endpackage

>>> src/cnpj_front.sv
// ----------------------------------------------------------------------------
// cnpj_front
// Input stage: takes items off the slave stream and flags out-of-range bases.
// ----------------------------------------------------------------------------
module cnpj_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cnpj_pkg::InDataW-1:0]  s_tdata,   // [39:0] base_number
    output logic                          push,
    output cnpj_pkg::item_t               push_item,
    input  logic                          queue_ready
);

    logic            fv_reg;
    cnpj_pkg::item_t item_reg;

    assign push      = fv_reg && queue_ready;
    assign s_tready  = !fv_reg || queue_ready;
    assign push_item = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            fv_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.base    <= s_tdata[cnpj_pkg::BaseW-1:0];
            item_reg.invalid <= (s_tdata[cnpj_pkg::BaseW-1:0] > cnpj_pkg::BaseLimit);
        end
    end

endmodule

>>> src/cnpj_fifo.sv
// ----------------------------------------------------------------------------
// cnpj_fifo
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module cnpj_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cnpj_pkg::item_t push_item,
    output logic            ready,
    input  logic            pop,
    output logic            head_valid,
    output cnpj_pkg::item_t head_item
);

    cnpj_pkg::item_t mem_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            do_pop;

    assign ready      = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> src/cnpj_back.sv
// ----------------------------------------------------------------------------
// cnpj_back
// Execution pipeline: binary to BCD, weighted sums, mod-11 digits, output reg.
// ----------------------------------------------------------------------------
module cnpj_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  cnpj_pkg::item_t               head_item,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cnpj_pkg::OutDataW-1:0] m_tdata,   // [46:0] full_number,
                                                     // [50:47] first_check,
                                                     // [54:51] second_check, [55] zero
    output logic                          m_tuser    // [0] invalid
);

    typedef struct packed {
        logic [cnpj_pkg::BaseW-1:0] base;
        logic [cnpj_pkg::BcdW-1:0]  bcd;
        logic                       invalid;
    } dd_t;

    typedef struct packed {
        logic [cnpj_pkg::FullW-1:0] base100;
        logic [cnpj_pkg::SumW-1:0]  sum1;
        logic [cnpj_pkg::SumW-1:0]  sum2b;
        logic                       invalid;
    } sum_t;

    typedef struct packed {
        logic [cnpj_pkg::FullW-1:0]  base100;
        logic [cnpj_pkg::DigitW-1:0] d1;
        logic [cnpj_pkg::SumW-1:0]   sum2;
        logic                        invalid;
    } chk_t;

    // one double-dabble step: correct digits of five or more, shift in a bit
    function automatic logic [cnpj_pkg::BcdW-1:0] dd_step(
        input logic [cnpj_pkg::BcdW-1:0] bcd,
        input logic                      bit_in
    );
        logic [cnpj_pkg::BcdW-1:0] t;
        t = bcd;
        for (int j = 0; j < cnpj_pkg::NumDigits; j++)
        begin
            if (t[j*cnpj_pkg::DigitW +: cnpj_pkg::DigitW] >= 4'd5)
            begin
                t[j*cnpj_pkg::DigitW +: cnpj_pkg::DigitW] =
                    t[j*cnpj_pkg::DigitW +: cnpj_pkg::DigitW] + 4'd3;
            end
        end
        return {t[cnpj_pkg::BcdW-2:0], bit_in};
    endfunction

    // x mod 11 by reciprocal (745/8192), exact for x below 2730; then the digit rule
    function automatic logic [cnpj_pkg::DigitW-1:0] check_digit(
        input logic [cnpj_pkg::SumW-1:0] x
    );
        logic [19:0] prod;
        logic [6:0]  q;
        logic [9:0]  q11;
        logic [3:0]  rem;
        prod = 20'(x) * 20'd745;
        q    = prod[19:13];
        q11  = {q, 3'b000} + {2'b00, q, 1'b0} + {3'b000, q};
        rem  = 4'(x - q11);
        return (rem <= 4'd1) ? 4'd0 : (4'd11 - rem);
    endfunction

    logic en;
    logic dd_vld_reg [cnpj_pkg::DdStages];
    dd_t  dd_reg     [cnpj_pkg::DdStages];
    dd_t  dd_next    [cnpj_pkg::DdStages];
    logic sum_vld_reg;
    sum_t sum_reg;
    sum_t sum_next;
    logic chk_vld_reg;
    chk_t chk_reg;
    chk_t chk_next;
    logic                          out_vld_reg;
    logic [cnpj_pkg::OutDataW-1:0] out_data_reg;
    logic [cnpj_pkg::OutDataW-1:0] out_data_next;
    logic                          out_user_reg;

    // whole pipeline moves together whenever the output register can take an item
    assign en       = !out_vld_reg || m_tready;
    assign pop      = en;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb
    begin
        dd_t                        src;
        logic [cnpj_pkg::BaseW-1:0] sh;
        for (int k = 0; k < cnpj_pkg::DdStages; k++)
        begin
            if (k == 0)
            begin
                src.base    = head_item.base;
                src.bcd     = '0;
                src.invalid = head_item.invalid;
            end
            else
            begin
                src = dd_reg[k-1];
            end
            sh = src.base << (cnpj_pkg::BitsPerStage * k);
            dd_next[k] = src;
            for (int b = 0; b < cnpj_pkg::BitsPerStage; b++)
            begin
                dd_next[k].bcd = dd_step(dd_next[k].bcd, sh[cnpj_pkg::BaseW-1]);
                sh = {sh[cnpj_pkg::BaseW-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        dd_t                        last;
        logic [cnpj_pkg::DigitW-1:0] d;
        last = dd_reg[cnpj_pkg::DdStages-1];
        sum_next.sum1  = '0;
        sum_next.sum2b = '0;
        // base digit k sits at position k for the first sum, k+1 for the second
        for (int k = 0; k < cnpj_pkg::NumDigits; k++)
        begin
            d = last.bcd[k*cnpj_pkg::DigitW +: cnpj_pkg::DigitW];
            sum_next.sum1  = sum_next.sum1
                           + cnpj_pkg::SumW'(d) * cnpj_pkg::SumW'(cnpj_pkg::Weights[k]);
            sum_next.sum2b = sum_next.sum2b
                           + cnpj_pkg::SumW'(d) * cnpj_pkg::SumW'(cnpj_pkg::Weights[k+1]);
        end
        sum_next.base100 = {1'b0, last.base, 6'b0}
                         + {2'b0, last.base, 5'b0}
                         + {5'b0, last.base, 2'b0};
        sum_next.invalid = last.invalid;
    end

    always_comb
    begin
        chk_next.base100 = sum_reg.base100;
        chk_next.d1      = check_digit(sum_reg.sum1);
        chk_next.sum2    = sum_reg.sum2b + {5'b0, chk_next.d1, 1'b0};
        chk_next.invalid = sum_reg.invalid;
    end

    always_comb
    begin
        logic [cnpj_pkg::DigitW-1:0] d2;
        logic [cnpj_pkg::FullW-1:0]  full;
        d2   = check_digit(chk_reg.sum2);
        full = chk_reg.base100
             + cnpj_pkg::FullW'({chk_reg.d1, 3'b000})
             + cnpj_pkg::FullW'({chk_reg.d1, 1'b0})
             + cnpj_pkg::FullW'(d2);
        if (chk_reg.invalid)
        begin
            out_data_next = '0;
        end
        else
        begin
            out_data_next = {1'b0, d2, chk_reg.d1, full};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < cnpj_pkg::DdStages; k++)
            begin
                dd_vld_reg[k] <= 1'b0;
            end
            sum_vld_reg <= 1'b0;
            chk_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            dd_vld_reg[0] <= head_valid;
            for (int k = 1; k < cnpj_pkg::DdStages; k++)
            begin
                dd_vld_reg[k] <= dd_vld_reg[k-1];
            end
            sum_vld_reg <= dd_vld_reg[cnpj_pkg::DdStages-1];
            chk_vld_reg <= sum_vld_reg;
            out_vld_reg <= chk_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < cnpj_pkg::DdStages; k++)
            begin
                dd_reg[k] <= dd_next[k];
            end
            sum_reg      <= sum_next;
            chk_reg      <= chk_next;
            out_data_reg <= out_data_next;
            out_user_reg <= chk_reg.invalid;
        end
    end

endmodule

>>> src/cnpj_check_digits_core.sv
// ----------------------------------------------------------------------------
// cnpj_check_digits_core
// CNPJ mod-11 check-digit generator: base number in, full number and digits out.
// ----------------------------------------------------------------------------
// Path from input accept to m_tvalid: front register, queue write,
//   8 BCD stages at 5 bits each, sum and digit registers, output register.
// Throughput: one item per cycle unless m_tready stalls; set by BCD pipe and out reg.
// Reset: rst_n clears all valid flags and queue pointers; payload is not reset.
module cnpj_check_digits_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cnpj_pkg::InDataW-1:0]  s_tdata,   // [39:0] base_number
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cnpj_pkg::OutDataW-1:0] m_tdata,   // [46:0] full_number,
                                                     // [50:47] first_check,
                                                     // [54:51] second_check, [55] zero
    output logic                          m_tuser    // [0] invalid
);

    logic            push;
    cnpj_pkg::item_t push_item;
    logic            queue_ready;
    logic            pop;
    logic            head_valid;
    cnpj_pkg::item_t head_item;

    cnpj_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .push        (push),
        .push_item   (push_item),
        .queue_ready (queue_ready)
    );

    cnpj_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .ready      (queue_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    cnpj_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

>>> src/cnpj_checker.sv
// ----------------------------------------------------------------------------
// cnpj_checker
// Port-level checks on the result stream of the check-digit core.
// ----------------------------------------------------------------------------
module cnpj_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cnpj_pkg::OutDataW-1:0] m_tdata,
    input logic                          m_tuser
);

    // an out-of-range base gives all-zero results
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("invalid item with non-zero data");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> ((m_tdata[50:47] <= 4'd9) && (m_tdata[54:51] <= 4'd9)
                                    && !m_tdata[55]))
        else $error("check digit out of range");

    // the second digit is the last decimal digit of the full number
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> ((m_tdata[46:0] % 47'd10) == 47'(m_tdata[54:51])))
        else $error("full number does not end in the second check digit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // no result is valid in the cycle that reset is released
    assert property (@(posedge clk) $rose(rst_n) |-> !m_tvalid)
        else $error("result right after reset");

endmodule

bind cnpj_check_digits_core cnpj_checker u_cnpj_checker (.*);

>>> bench/cnpj_check_digits_core_tb.sv
// ----------------------------------------------------------------------------
// cnpj_check_digits_core_tb
// Self-checking bench for the CNPJ mod-11 check-digit core: directed corner
// items, then random base numbers under varied source and sink idling, with
// every result compared field by field against an in-bench prediction.
// ----------------------------------------------------------------------------
module cnpj_check_digits_core_tb;

    localparam int CycleLimit = 200000;
    localparam int DrainCycles = 40;
    localparam longint unsigned MaxBase = 64'd999999999999;

    typedef struct packed {
        logic [cnpj_pkg::FullW-1:0]  full_number;
        logic [cnpj_pkg::DigitW-1:0] first_check;
        logic [cnpj_pkg::DigitW-1:0] second_check;
        logic                        invalid;
    } cnpj_result_t;

    class CheckDigitBoard;
        cnpj_result_t pending[$];
        int unsigned  mismatches;
        int unsigned  weight_seq[13] = '{2, 3, 4, 5, 6, 7, 8, 9, 2, 3, 4, 5, 6};

        function new();
            mismatches = 0;
        endfunction

        // weighted mod-11 digit over the lowest ndig decimal digits
        function logic [cnpj_pkg::DigitW-1:0] mod11_digit(longint unsigned v, int ndig);
            int unsigned sum;
            int unsigned rem;
            sum = 0;
            for (int k = 0; k < ndig; k++)
            begin
                sum += int'(v % 10) * weight_seq[k];
                v = v / 10;
            end
            rem = sum % 11;
            return (11 - rem >= 10) ? 4'd0 : 4'(11 - rem);
        endfunction

        function void note_base(logic [cnpj_pkg::BaseW-1:0] base);
            cnpj_result_t    r;
            longint unsigned b;
            longint unsigned with_first;
            b = longint'(base);
            r = '0;
            if (b > MaxBase)
            begin
                r.invalid = 1'b1;
            end
            else
            begin
                r.first_check  = mod11_digit(b, 12);
                with_first     = b * 10 + r.first_check;
                r.second_check = mod11_digit(with_first, 13);
                r.full_number  = cnpj_pkg::FullW'(with_first * 10 + r.second_check);
            end
            pending.push_back(r);
        endfunction

        function void flag(string what, longint unsigned exp_v, longint unsigned act_v);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d, got %0d", what, exp_v, act_v);
        endfunction

        function void check_result(logic [cnpj_pkg::OutDataW-1:0] data, logic user);
            cnpj_result_t e;
            if (pending.size() == 0)
            begin
                flag("unexpected item, tdata", 0, data);
                return;
            end
            e = pending.pop_front();
            if (data[46:0] !== e.full_number)
                flag("full_number", e.full_number, data[46:0]);
            if (data[50:47] !== e.first_check)
                flag("first_check", e.first_check, data[50:47]);
            if (data[54:51] !== e.second_check)
                flag("second_check", e.second_check, data[54:51]);
            if (data[55] !== 1'b0)
                flag("tdata pad bit", 0, data[55]);
            if (user !== e.invalid)
                flag("invalid", e.invalid, user);
        endfunction

        function int count();
            return pending.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [cnpj_pkg::InDataW-1:0]  s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [cnpj_pkg::OutDataW-1:0] m_tdata;
    logic                          m_tuser;

    CheckDigitBoard board;
    int unsigned    src_idle_pct = 0;
    int unsigned    snk_stall_pct = 0;
    int unsigned    hold_len = 0;
    int unsigned    cycle_count = 0;

    cnpj_check_digits_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CycleLimit)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // sink: check accepted items, then pick tready for the next cycle
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                board.check_result(m_tdata, m_tuser);
            if (hold_len > 0)
            begin
                hold_len--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
            end
        end
    end

    task automatic send_base(input logic [cnpj_pkg::BaseW-1:0] base);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(0, 99) < src_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= base;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_base(base);
    endtask

    task automatic send_random(input int n);
        logic [cnpj_pkg::BaseW-1:0] b;
        int unsigned                pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                b = {8'($urandom), 32'($urandom)};
            else if (pick < 20)
                b = cnpj_pkg::BaseW'($urandom_range(0, 99999));
            else if (pick < 26)
                b = cnpj_pkg::BaseLimit - cnpj_pkg::BaseW'($urandom_range(0, 20))
                  + cnpj_pkg::BaseW'($urandom_range(0, 40));
            else
                b = cnpj_pkg::BaseW'(longint'($urandom_range(0, 999999)) * 1000000
                                     + longint'($urandom_range(0, 999999)));
            send_base(b);
        end
    endtask

    task automatic wait_empty();
        while (board.count() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        board = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // corners: zeros, limit either side, all-ones, top bit set and clear, repeated digits
        send_base(40'd0);
        send_base(40'd1);
        send_base(40'd10);
        send_base(40'd999999999999);
        send_base(40'd1000000000000);
        send_base(40'd999999999998);
        send_base({cnpj_pkg::BaseW{1'b1}});
        send_base(40'h80_0000_0000);
        send_base(40'h7F_FFFF_FFFF);
        send_base(40'd112223330001);
        send_base(40'd111111111111);
        send_base(40'd555555555555);
        send_base(40'd123456789012);
        send_base(40'd100000000000);
        send_base(40'd000000000019);
        send_base(40'd909090909090);

        send_random(100);
        src_idle_pct = 58;
        send_random(100);
        src_idle_pct  = 0;
        snk_stall_pct = 58;
        send_random(100);
        src_idle_pct  = 30;
        snk_stall_pct = 30;
        send_random(100);

        // back-pressure: sink holds off while the source keeps offering
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_len      = 80;
        send_random(40);
        s_tvalid <= 1'b0;
        wait_empty();
        send_random(20);
        s_tvalid <= 1'b0;

        wait_empty();
        repeat (DrainCycles) @(posedge clk);

        if (board.mismatches == 0 && board.count() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
